@@ hw/rtl/debounced_button_square_wave_top_assert.svh @@
// ----------------------------------------------------------------------------
// debounced button square wave - assertion macros
// Wrappers for concurrent checks, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_BUTTON_SQUARE_WAVE_TOP_ASSERT_SVH
`define DEBOUNCED_BUTTON_SQUARE_WAVE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// check outside reset
`define DBSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// check that also holds while reset is applied
`define DBSW_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define DBSW_ASSERT(lbl, prop, msg)
`define DBSW_ASSERT_ANY(lbl, prop, msg)
`endif

`endif

@@ hw/rtl/dbsw_pkg.sv @@
// ----------------------------------------------------------------------------
// dbsw_pkg
// Shared constants and types of the debounced button square wave block.
// ----------------------------------------------------------------------------
package dbsw_pkg;

  localparam int PERIOD_WIDTH = 16;
  localparam int PHASE_W      = PERIOD_WIDTH + 1;
  localparam int ADJ_W        = ((PERIOD_WIDTH > 16) ? PERIOD_WIDTH : 16) + 1;

  localparam int DEBOUNCE_W   = 8;
  localparam int STEP_W       = 15;
  localparam int HALF_OUT_W   = 16;
  localparam int BTN_W        = 2;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(12);
  localparam logic [STEP_W-1:0]     STEP_RESET     = STEP_W'(50);

  // register map
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_STEP     = 1'b1;

  // packed result: wave, accepted buttons, half period, zero fill
  localparam int RES_BITS = 1 + BTN_W + HALF_OUT_W;
  localparam int OUT_W    = ((RES_BITS + 7) / 8) * 8;
  localparam int IN_W     = 8;

  typedef struct packed {
    logic [BTN_W-1:0] accepted;  // debounced pattern after this transaction
    logic             adjust;    // release seen, half period is adjusted
    logic [BTN_W-1:0] pattern;   // pattern held before the release
  } db_status_t;

endpackage

@@ hw/rtl/debounced_button_square_wave_top.sv @@
// output: a result reaches the master side through the output register, or the skid entry while that is full
// throughput: one transaction per cycle while the skid entry is empty; a two-entry output buffer keeps the input
//   side open while a single result waits to be taken
// reset: asynchronous, active low; registers other than the output data return to their power-on values,
//   the debounce hold counter reloads to twelve ticks and no result is pending
// ----------------------------------------------------------------------------
// debounced_button_square_wave_top
// Debounces two buttons, adjusts the half period on release and emits a square wave.
// ----------------------------------------------------------------------------
`include "debounced_button_square_wave_top_assert.svh"

module debounced_button_square_wave_top
  import dbsw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // apb configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,   // [0] button_up_n, [1] button_down_n
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata    // [0] wave_out, [2:1] accepted_buttons,
                                                // [18:3] half_period
);

  logic                    in_acc;
  logic [BTN_W-1:0]        sample;
  logic [DEBOUNCE_W-1:0]   debounce_ticks;
  logic [STEP_W-1:0]       step_size;
  db_status_t              db_status;
  logic                    wave;
  logic [PERIOD_WIDTH-1:0] half_d, half_q;
  logic [OUT_W-1:0]        result;

  assign in_acc = s_axis_tvalid & s_axis_tready;
  // active-low levels become pressed bits
  assign sample = {~s_axis_tdata[1], ~s_axis_tdata[0]};

  dbsw_cfg u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .debounce_ticks_o (debounce_ticks),
    .step_size_o      (step_size)
  );

  dbsw_debounce u_debounce (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (in_acc),
    .sample_i         (sample),
    .debounce_ticks_i (debounce_ticks),
    .status_o         (db_status)
  );

  dbsw_wave u_wave (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (in_acc),
    .status_i    (db_status),
    .step_size_i (step_size),
    .wave_o      (wave),
    .half_d_o    (half_d),
    .half_q_o    (half_q)
  );

  assign result = OUT_W'({HALF_OUT_W'(half_d), db_status.accepted, wave});

  dbsw_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_acc),
    .in_data_i   (result),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_ready_i (m_axis_tready)
  );

  // input side only closes while a result is held
  `DBSW_ASSERT(a_stall_has_result, !s_axis_tready |-> m_axis_tvalid, "input stalled with empty output")
  // half period only moves on a transaction that carries a release
  `DBSW_ASSERT(a_half_hold, !(in_acc && db_status.adjust) |=> $stable(half_q), "half period changed without release")
  // after a transaction the output is always valid on the next cycle
  `DBSW_ASSERT(a_result_follows, in_acc |=> m_axis_tvalid, "accepted transaction produced no result")

endmodule

@@ hw/rtl/dbsw_cfg.sv @@
// ----------------------------------------------------------------------------
// dbsw_cfg
// APB register file: debounce tick count and half period step size.
// ----------------------------------------------------------------------------
module dbsw_cfg
  import dbsw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [DEBOUNCE_W-1:0] debounce_ticks_o,
  output logic [STEP_W-1:0]     step_size_o
);

  logic [DEBOUNCE_W-1:0] debounce_ticks_q;
  logic [STEP_W-1:0]     step_size_q;
  logic                  wr_en;
  logic                  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= DEBOUNCE_RESET;
      step_size_q      <= STEP_RESET;
    end else if (wr_en) begin
      if (reg_sel == REG_DEBOUNCE) begin
        debounce_ticks_q <= pwdata[DEBOUNCE_W-1:0];
      end else begin
        step_size_q <= pwdata[STEP_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == REG_DEBOUNCE) begin
      prdata = CFG_DATA_W'(debounce_ticks_q);
    end else begin
      prdata = CFG_DATA_W'(step_size_q);
    end
  end

  assign debounce_ticks_o = debounce_ticks_q;
  assign step_size_o      = step_size_q;

endmodule

@@ hw/rtl/dbsw_debounce.sv @@
// ----------------------------------------------------------------------------
// dbsw_debounce
// Two-bit debouncer with saturating hold counter and release detection.
// ----------------------------------------------------------------------------
module dbsw_debounce
  import dbsw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [BTN_W-1:0]      sample_i,
  input  logic [DEBOUNCE_W-1:0] debounce_ticks_i,
  output db_status_t            status_o
);

  logic [BTN_W-1:0]      last_q, last_d;
  logic [DEBOUNCE_W-1:0] stable_q, stable_d;
  logic [BTN_W-1:0]      acc_q, acc_d;
  logic [BTN_W-1:0]      prev_q;

  always_comb begin
    last_d   = last_q;
    stable_d = stable_q;
    if (sample_i == last_q) begin
      if (stable_q != '0) begin
        stable_d = stable_q - DEBOUNCE_W'(1);
      end
    end else begin
      last_d   = sample_i;
      stable_d = debounce_ticks_i;
    end
    acc_d = (stable_d == '0) ? sample_i : acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      stable_q <= DEBOUNCE_RESET;
      acc_q    <= '0;
      prev_q   <= '0;
    end else if (en_i) begin
      last_q   <= last_d;
      stable_q <= stable_d;
      acc_q    <= acc_d;
      prev_q   <= acc_d;
    end
  end

  assign status_o.accepted = acc_d;
  assign status_o.adjust   = (acc_d == '0) && (prev_q != '0);
  assign status_o.pattern  = prev_q;

endmodule

@@ hw/rtl/dbsw_wave.sv @@
// ----------------------------------------------------------------------------
// dbsw_wave
// Half period adjustment on release and phase counter square wave.
// ----------------------------------------------------------------------------
module dbsw_wave
  import dbsw_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  db_status_t              status_i,
  input  logic [STEP_W-1:0]       step_size_i,
  output logic                    wave_o,
  output logic [PERIOD_WIDTH-1:0] half_d_o,
  output logic [PERIOD_WIDTH-1:0] half_q_o
);

  localparam logic [ADJ_W-1:0] HALF_MAX = ADJ_W'({PERIOD_WIDTH{1'b1}});

  logic [PERIOD_WIDTH-1:0] half_q, half_d;
  logic [PHASE_W-1:0]      phase_q, phase_d;
  logic [ADJ_W-1:0]        half_w, step_w, two_step;
  logic [ADJ_W-1:0]        dec_base, dec, dec_sat, after_dec, inc, inc_sat, after_inc;
  logic [PHASE_W-1:0]      half_p, two_half;
  logic                    below_half, below_two;
  logic [PHASE_W-1:0]      phase_base;

  always_comb begin
    half_w   = ADJ_W'(half_q);
    step_w   = ADJ_W'(step_size_i);
    two_step = ADJ_W'({step_size_i, 1'b0});

    // decrease: lift to twice the step first so the result stays at least step
    dec_base  = (half_w < two_step) ? two_step : half_w;
    dec       = dec_base - step_w;
    dec_sat   = (dec > HALF_MAX) ? HALF_MAX : dec;
    after_dec = status_i.pattern[1] ? dec_sat : half_w;

    inc       = after_dec + step_w;
    inc_sat   = (inc > HALF_MAX) ? HALF_MAX : inc;
    after_inc = status_i.pattern[0] ? inc_sat : after_dec;

    half_d = status_i.adjust ? PERIOD_WIDTH'(after_inc) : half_q;

    half_p     = PHASE_W'(half_d);
    two_half   = {half_d, 1'b0};
    below_half = phase_q < half_p;
    below_two  = phase_q < two_half;
    wave_o     = below_half | ~below_two;
    phase_base = (below_half | below_two) ? phase_q : '0;
    phase_d    = phase_base + PHASE_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= '0;
      phase_q <= '0;
    end else if (en_i) begin
      half_q  <= half_d;
      phase_q <= phase_d;
    end
  end

  assign half_d_o = half_d;
  assign half_q_o = half_q;

endmodule

@@ hw/rtl/dbsw_skid.sv @@
// ----------------------------------------------------------------------------
// dbsw_skid
// Output register with a skid entry so the input side ready is registered.
// ----------------------------------------------------------------------------
module dbsw_skid
  import dbsw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [OUT_W-1:0] in_data_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output logic [OUT_W-1:0] out_data_o,
  input  logic             out_ready_i
);

  logic             out_valid_q, skid_valid_q;
  logic [OUT_W-1:0] out_data_q, skid_data_q;
  logic             out_free;

  assign in_ready_o = ~skid_valid_q;
  assign out_free   = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_valid_i;
      end
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : in_data_i;
    end
    if (!out_free && !skid_valid_q) begin
      skid_data_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ sim/tb_debounced_button_square_wave_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_debounced_button_square_wave_top
// Streams button sample transactions through the block and compares each
// result with an in-bench model of the debouncer, the half period update and
// the square wave phase counter, across several debounce and step settings.
// ----------------------------------------------------------------------------
module tb_debounced_button_square_wave_top;
  import dbsw_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLDOFF_CYCLES = 150;
  localparam int RESULT_LATENCY = 1;
  localparam int MAX_REPORTS    = 10;

  localparam longint unsigned HALF_MAX   = (64'd1 << PERIOD_WIDTH) - 64'd1;
  localparam longint unsigned PHASE_MASK = (64'd1 << PHASE_W) - 64'd1;

  // packed in the same order as the result stream, wave in bit 0
  typedef struct packed {
    logic [HALF_OUT_W-1:0] half;
    logic [BTN_W-1:0]      accepted;
    logic                  wave;
  } wave_result_t;

  localparam wave_result_t AFTER_RESET_TICK = {{HALF_OUT_W{1'b0}}, {BTN_W{1'b0}}, 1'b1};

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic        reg_sel;
    int unsigned value;
    bit          up_n;
    bit          down_n;
    bit          typed;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_valid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_data = '0;
  logic                  m_axis_tvalid;
  logic                  m_ready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;

  // model state
  logic [DEBOUNCE_W-1:0] debounce_q;
  logic [STEP_W-1:0]     step_q;
  logic [BTN_W-1:0]      smp_last;
  logic [DEBOUNCE_W-1:0] hold_left;
  logic [BTN_W-1:0]      btn_accepted;
  logic [BTN_W-1:0]      btn_prev;
  longint unsigned       half_q;
  longint unsigned       phase_q;

  wave_result_t expected_ticks[$];
  stim_row_t    directed_rows[$];
  int           mismatch_count = 0;
  int           items_sent = 0;
  int           cycle_count = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           holdoff_requests = 0;
  int           holdoff_served = 0;
  int           holdoff_left = 0;

  debounced_button_square_wave_top i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // one sampling tick of the block
  function automatic wave_result_t predict_tick(bit up_n, bit down_n);
    logic [BTN_W-1:0] smp;
    wave_result_t     res;
    longint unsigned  step;
    smp = {~down_n, ~up_n};
    step = step_q;
    if (smp == smp_last) begin
      if (hold_left != 0) hold_left = hold_left - 1'b1;
    end else begin
      smp_last = smp;
      hold_left = debounce_q;
    end
    if (hold_left == 0) btn_accepted = smp;
    // release: adjust by the pattern held just before it, decrease first
    if (btn_accepted == 0 && btn_prev != 0) begin
      if (btn_prev[1]) begin
        if (half_q < 2 * step) half_q = 2 * step;
        half_q = half_q - step;
        if (half_q > HALF_MAX) half_q = HALF_MAX;
      end
      if (btn_prev[0]) begin
        half_q = half_q + step;
        if (half_q > HALF_MAX) half_q = HALF_MAX;
      end
    end
    if (phase_q < half_q) begin
      res.wave = 1'b1;
    end else if (phase_q < 2 * half_q) begin
      res.wave = 1'b0;
    end else begin
      phase_q = 0;
      res.wave = 1'b1;
    end
    btn_prev = btn_accepted;
    phase_q = (phase_q + 1) & PHASE_MASK;
    res.accepted = btn_accepted;
    res.half = half_q[HALF_OUT_W-1:0];
    return res;
  endfunction

  function automatic stim_row_t tick_row(bit up_n, bit down_n, bit typed);
    stim_row_t row;
    row.kind = ROW_TICK;
    row.reg_sel = REG_DEBOUNCE;
    row.value = 0;
    row.up_n = up_n;
    row.down_n = down_n;
    row.typed = typed;
    return row;
  endfunction

  function automatic stim_row_t write_row(logic reg_sel, int unsigned value);
    stim_row_t row;
    row = tick_row(1'b1, 1'b1, 1'b0);
    row.kind = ROW_WRITE;
    row.reg_sel = reg_sel;
    row.value = value;
    return row;
  endfunction

  // result stream receiver with random stalls and the long hold-off
  always @(posedge clk) begin
    if (holdoff_requests != holdoff_served) begin
      holdoff_served <= holdoff_requests;
      holdoff_left <= HOLDOFF_CYCLES;
      m_ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    wave_result_t got;
    wave_result_t want;
    if (rst_n && m_axis_tvalid && m_ready) begin
      got = m_axis_tdata[RES_BITS-1:0];
      if (expected_ticks.size() == 0) begin
        note_mismatch($sformatf("unexpected result transaction: wave %0d buttons %0d half %0d",
                                got.wave, got.accepted, got.half));
      end else begin
        want = expected_ticks.pop_front();
        if (got.wave !== want.wave || got.accepted !== want.accepted ||
            got.half !== want.half) begin
          note_mismatch($sformatf(
            "result mismatch: expected wave %0d buttons %0d half %0d, got wave %0d buttons %0d half %0d",
            want.wave, want.accepted, want.half, got.wave, got.accepted, got.half));
        end
      end
    end
  end

  task automatic send_sample(bit up_n, bit down_n, bit typed);
    wave_result_t    res;
    logic [IN_W-1:0] word;
    // sender idles cycle by cycle at the chosen rate
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    word = IN_W'($urandom());
    word[1:0] = {down_n, up_n};
    s_valid <= 1'b1;
    s_data <= word;
    do @(posedge clk); while (!s_axis_tready);
    res = predict_tick(up_n, down_n);
    expected_ticks.push_back(typed ? AFTER_RESET_TICK : res);
    items_sent++;
  endtask

  task automatic drain_results();
    s_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 3) @(posedge clk);
  endtask

  // write then read back one register, block idle
  task automatic cfg_write(logic reg_sel, int unsigned value);
    logic [CFG_DATA_W-1:0] wdata;
    logic [CFG_DATA_W-1:0] rd_want;
    wdata = $urandom();
    if (reg_sel == REG_DEBOUNCE) wdata[DEBOUNCE_W-1:0] = DEBOUNCE_W'(value);
    else wdata[STEP_W-1:0] = STEP_W'(value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'({reg_sel, 2'b00});
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (reg_sel == REG_DEBOUNCE) begin
      debounce_q = wdata[DEBOUNCE_W-1:0];
      rd_want = CFG_DATA_W'(debounce_q);
    end else begin
      step_q = wdata[STEP_W-1:0];
      rd_want = CFG_DATA_W'(step_q);
    end
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== rd_want)
      note_mismatch($sformatf("register %0d readback: expected %0h, got %0h",
                              reg_sel, rd_want, prdata));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic press_release(logic [BTN_W-1:0] pat, int hold, int rel);
    repeat ($urandom_range(0, 3))
      send_sample(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
    repeat (hold) send_sample(~pat[0], ~pat[1], 1'b0);
    repeat ($urandom_range(0, 2))
      send_sample(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
    repeat (rel) send_sample(1'b1, 1'b1, 1'b0);
  endtask

  task automatic run_presses(int n_items);
    int               stop_at;
    int               kind;
    int               dbt;
    logic [BTN_W-1:0] pat;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      dbt = debounce_q;
      pat = BTN_W'($urandom_range(1, 3));
      if (kind < 70) begin
        press_release(pat, dbt + 1 + $urandom_range(0, 3), dbt + 1 + $urandom_range(0, 3));
      end else if (kind < 85) begin
        // press or release too short to be accepted
        press_release(pat, $urandom_range(1, (dbt > 1) ? dbt : 1),
                      $urandom_range(1, (dbt > 1) ? dbt : 1));
      end else begin
        repeat ($urandom_range(1, 6))
          send_sample(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    debounce_q = DEBOUNCE_RESET;
    step_q = STEP_RESET;
    smp_last = '0;
    hold_left = DEBOUNCE_RESET;
    btn_accepted = '0;
    btn_prev = '0;
    half_q = 0;
    phase_q = 0;

    // after reset: zero half period keeps the wave high
    directed_rows.push_back(tick_row(1'b1, 1'b1, 1'b1));
    directed_rows.push_back(tick_row(1'b1, 1'b1, 1'b1));
    directed_rows.push_back(tick_row(1'b1, 1'b1, 1'b1));
    directed_rows.push_back(tick_row(1'b0, 1'b0, 1'b1));
    // zero debounce: patterns accepted on first appearance
    directed_rows.push_back(write_row(REG_DEBOUNCE, 0));
    directed_rows.push_back(tick_row(1'b0, 1'b1, 1'b0));
    directed_rows.push_back(tick_row(1'b1, 1'b1, 1'b0));
    directed_rows.push_back(tick_row(1'b1, 1'b0, 1'b0));
    directed_rows.push_back(tick_row(1'b1, 1'b1, 1'b0));
    directed_rows.push_back(tick_row(1'b0, 1'b0, 1'b0));
    directed_rows.push_back(tick_row(1'b1, 1'b1, 1'b0));
    // largest step: increase saturates, decrease from the top
    directed_rows.push_back(write_row(REG_STEP, 32767));
    directed_rows.push_back(tick_row(1'b0, 1'b1, 1'b0));
    directed_rows.push_back(tick_row(1'b1, 1'b1, 1'b0));
    directed_rows.push_back(tick_row(1'b0, 1'b1, 1'b0));
    directed_rows.push_back(tick_row(1'b1, 1'b1, 1'b0));
    directed_rows.push_back(tick_row(1'b1, 1'b0, 1'b0));
    directed_rows.push_back(tick_row(1'b1, 1'b1, 1'b0));
    // zero step leaves the half period alone
    directed_rows.push_back(write_row(REG_STEP, 0));
    directed_rows.push_back(tick_row(1'b1, 1'b0, 1'b0));
    directed_rows.push_back(tick_row(1'b1, 1'b1, 1'b0));
    directed_rows.push_back(write_row(REG_DEBOUNCE, 1));
    directed_rows.push_back(write_row(REG_STEP, 50));
    directed_rows.push_back(tick_row(1'b0, 1'b1, 1'b0));
    directed_rows.push_back(tick_row(1'b0, 1'b1, 1'b0));
    directed_rows.push_back(tick_row(1'b1, 1'b1, 1'b0));
    directed_rows.push_back(tick_row(1'b1, 1'b1, 1'b0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 23;
    rx_idle_pct = 75;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        drain_results();
        cfg_write(directed_rows[i].reg_sel, directed_rows[i].value);
      end else begin
        send_sample(directed_rows[i].up_n, directed_rows[i].down_n, directed_rows[i].typed);
      end
    end

    drain_results();
    cfg_write(REG_DEBOUNCE, 3);
    cfg_write(REG_STEP, 50);
    run_presses(50);

    // receiver stops for a long stretch while samples keep coming
    drain_results();
    cfg_write(REG_DEBOUNCE, 2);
    cfg_write(REG_STEP, $urandom_range(1, 32767));
    run_presses(30);
    holdoff_requests++;
    run_presses(50);

    tx_idle_pct = 75;
    rx_idle_pct = 23;
    drain_results();
    cfg_write(REG_DEBOUNCE, 1);
    cfg_write(REG_STEP, 32767);
    run_presses(30);
    drain_results();
    run_presses(30);

    drain_results();
    cfg_write(REG_DEBOUNCE, $urandom_range(1, 8));
    cfg_write(REG_STEP, $urandom_range(1, 32767));
    run_presses(50);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    drain_results();
    cfg_write(REG_DEBOUNCE, 255);
    cfg_write(REG_STEP, 1);
    press_release(2'b10, 257, 0);
    // release the long press with a short hold time
    drain_results();
    cfg_write(REG_DEBOUNCE, 1);
    repeat (3) send_sample(1'b1, 1'b1, 1'b0);

    drain_results();
    cfg_write(REG_DEBOUNCE, 4);
    cfg_write(REG_STEP, 1000);
    run_presses(40);

    drain_results();
    if (mismatch_count == 0 && expected_ticks.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/dbsw_pkg.sv
hw/rtl/dbsw_cfg.sv
hw/rtl/dbsw_debounce.sv
hw/rtl/dbsw_wave.sv
hw/rtl/dbsw_skid.sv
hw/rtl/debounced_button_square_wave_top.sv
sim/tb_debounced_button_square_wave_top.sv
